// ===== hdl/http_request_header_tokenizer_defines.svh =====
// Assertion macros for the HTTP request header tokenizer.
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_DEFINES_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset
`define HRHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset
`define HRHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hrht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hrht_pkg;

  // Parser phase
  typedef enum logic [3:0] {
    PH_METHOD   = 4'd0,
    PH_P_SECOND = 4'd1,
    PH_SKIP_M   = 4'd2,
    PH_URI      = 4'd3,
    PH_VERSION  = 4'd4,
    PH_LINE     = 4'd5,
    PH_NAME     = 4'd6,
    PH_LEADSP   = 4'd7,
    PH_VALUE    = 4'd8,
    PH_DROP     = 4'd9,
    PH_DONE     = 4'd10
  } phase_e;

  // Item kinds on the output stream
  typedef enum logic [2:0] {
    KIND_METHOD = 3'd0,
    KIND_URI    = 3'd1,
    KIND_NAME   = 3'd2,
    KIND_VALUE  = 3'd3,
    KIND_HEND   = 3'd4,
    KIND_REND   = 3'd5
  } kind_e;

  // Method codes
  localparam logic [3:0] METH_UNKNOWN = 4'd0;
  localparam logic [3:0] METH_GET     = 4'd1;
  localparam logic [3:0] METH_PUT     = 4'd2;
  localparam logic [3:0] METH_POST    = 4'd3;
  localparam logic [3:0] METH_HEAD    = 4'd4;
  localparam logic [3:0] METH_DELETE  = 4'd5;
  localparam logic [3:0] METH_TRACE   = 4'd6;
  localparam logic [3:0] METH_CONNECT = 4'd7;
  localparam logic [3:0] METH_OPTIONS = 4'd8;

  // Characters of interest
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Registered input byte
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // One result item
  typedef struct packed {
    kind_e      item_kind;
    logic [7:0] item_byte;
    logic [3:0] method_code;
    logic       request_end;
  } item_t;

  // Method from the first letter (P is resolved by the second letter)
  function automatic logic [3:0] first_method(input logic [7:0] b);
    logic [3:0] m;
    case (b)
      CH_G:    m = METH_GET;
      CH_H:    m = METH_HEAD;
      CH_D:    m = METH_DELETE;
      CH_T:    m = METH_TRACE;
      CH_C:    m = METH_CONNECT;
      CH_O:    m = METH_OPTIONS;
      default: m = METH_UNKNOWN;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hrht_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hrht_in_stage (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic        take_i,      // held byte is consumed this cycle
  output hrht_pkg::in_t    in_o
);

  import hrht_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;

  // Room when empty or when the held byte moves on this cycle
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign in_o.valid     = valid_q;
  assign in_o.data_byte = byte_q;
  assign in_o.last_byte = last_q;

endmodule

`default_nettype wire

// ===== hdl/hrht_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hrht_step (
  input  wire hrht_pkg::phase_e phase_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output hrht_pkg::phase_e phase_o,
  output logic             item_valid_o,
  output hrht_pkg::item_t  item_o
);

  import hrht_pkg::*;

  logic  emit;
  kind_e kind;
  logic [7:0] ibyte;
  logic [3:0] meth;
  phase_e nxt;

  // Next phase and item for one byte
  always_comb begin
    emit  = 1'b0;
    kind  = KIND_METHOD;
    ibyte = 8'd0;
    meth  = METH_UNKNOWN;
    nxt   = phase_i;
    case (phase_i)
      PH_P_SECOND: begin
        emit = 1'b1;
        meth = (data_byte_i == CH_U) ? METH_PUT : METH_POST;
        nxt  = (data_byte_i == CH_SPACE) ? PH_URI : PH_SKIP_M;
      end
      PH_SKIP_M: begin
        if (data_byte_i == CH_SPACE) nxt = PH_URI;
      end
      PH_URI: begin
        if (data_byte_i == CH_SPACE) begin
          nxt = PH_VERSION;
        end else begin
          emit  = 1'b1;
          kind  = KIND_URI;
          ibyte = data_byte_i;
        end
      end
      PH_VERSION: begin
        if (data_byte_i == CH_LF) nxt = PH_LINE;
      end
      PH_LINE: begin
        if (data_byte_i == CH_CR) begin
          emit = 1'b1;
          kind = KIND_REND;
          nxt  = PH_DONE;
        end else if (data_byte_i == CH_COLON) begin
          nxt = PH_LEADSP;
        end else begin
          emit  = 1'b1;
          kind  = KIND_NAME;
          ibyte = data_byte_i;
          nxt   = PH_NAME;
        end
      end
      PH_NAME: begin
        if (data_byte_i == CH_COLON) begin
          nxt = PH_LEADSP;
        end else begin
          emit  = 1'b1;
          kind  = KIND_NAME;
          ibyte = data_byte_i;
        end
      end
      PH_LEADSP: begin
        if (data_byte_i == CH_CR) begin
          emit = 1'b1;
          kind = KIND_HEND;
          nxt  = PH_DROP;
        end else if (data_byte_i != CH_SPACE) begin
          emit  = 1'b1;
          kind  = KIND_VALUE;
          ibyte = data_byte_i;
          nxt   = PH_VALUE;
        end
      end
      PH_VALUE: begin
        emit = 1'b1;
        if (data_byte_i == CH_CR) begin
          kind = KIND_HEND;
          nxt  = PH_DROP;
        end else begin
          kind  = KIND_VALUE;
          ibyte = data_byte_i;
        end
      end
      PH_DROP: begin
        nxt = PH_LINE;
      end
      PH_DONE: begin
        nxt = PH_DONE;
      end
      default: begin
        // awaiting the first method byte
        if (data_byte_i == CH_P) begin
          emit = last_byte_i;
          meth = METH_POST;
          nxt  = PH_P_SECOND;
        end else begin
          emit = 1'b1;
          meth = first_method(data_byte_i);
          nxt  = (data_byte_i == CH_SPACE) ? PH_URI : PH_SKIP_M;
        end
      end
    endcase

    // Last byte closes the request and rewinds the parser
    if (last_byte_i) begin
      if (!emit) begin
        emit  = 1'b1;
        kind  = KIND_REND;
        ibyte = 8'd0;
        meth  = METH_UNKNOWN;
      end
      nxt = PH_METHOD;
    end
  end

  assign phase_o             = nxt;
  assign item_valid_o        = emit;
  assign item_o.item_kind    = kind;
  assign item_o.item_byte    = ibyte;
  assign item_o.method_code  = meth;
  assign item_o.request_end  = last_byte_i;

endmodule

`default_nettype wire

// ===== hdl/http_request_header_tokenizer.sv =====
// Path: a byte accepted into the input register is decoded, and its item (if
//   any) is written into the output register, from which it can be taken.
// Throughput: one byte per clock; the input register and output register
//   sit around a single combinational decode step. Input stalls only while
//   an item waits in the output register with m_axis_tready_i low.
// Reset (rst_ni low, asynchronous): parser waits for the first method byte,
//   input and output stages are emptied.
`timescale 1ns / 1ps
`default_nettype none

`include "http_request_header_tokenizer_defines.svh"

module http_request_header_tokenizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,   // last_byte
  // item stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] item_byte, [11:8] method_code
  output logic [2:0]       m_axis_tuser_o,   // [2:0] item_kind
  output logic             m_axis_tlast_o    // request_end
);

  import hrht_pkg::*;

  in_t    in_s;
  logic   advance;
  phase_e phase_q, phase_d;
  logic   step_valid;
  item_t  step_item;
  logic   out_valid_q, out_valid_d;
  item_t  out_q;

  // Held byte moves on whenever the output register has room
  assign advance = in_s.valid && (!out_valid_q || m_axis_tready_i);

  hrht_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid_i),
    .ready_o     (s_axis_tready_o),
    .data_byte_i (s_axis_tdata_i),
    .last_byte_i (s_axis_tlast_i),
    .take_i      (advance),
    .in_o        (in_s)
  );

  hrht_step u_step (
    .phase_i      (phase_q),
    .data_byte_i  (in_s.data_byte),
    .last_byte_i  (in_s.last_byte),
    .phase_o      (phase_d),
    .item_valid_o (step_valid),
    .item_o       (step_item)
  );

  // Output register next state
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = step_valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_METHOD;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q <= phase_d;
      end
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    if (advance && step_valid) begin
      out_q <= step_item;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_q.method_code, out_q.item_byte};
  assign m_axis_tuser_o  = out_q.item_kind;
  assign m_axis_tlast_o  = out_q.request_end;

  // Checks
  `HRHT_ASSERT_NOW(a_meth_only_on_method,
    out_valid_q && (out_q.item_kind != KIND_METHOD),
    out_q.method_code == METH_UNKNOWN, "method code on non-method item")
  `HRHT_ASSERT_NOW(a_byte_zero_no_data,
    out_valid_q && (out_q.item_kind == KIND_METHOD || out_q.item_kind == KIND_HEND ||
                    out_q.item_kind == KIND_REND),
    out_q.item_byte == 8'd0, "byte on item without data")
  `HRHT_ASSERT_NEXT(a_last_rewinds, advance && in_s.last_byte,
    phase_q == PH_METHOD, "parser not rewound after last byte")
  `HRHT_ASSERT_NEXT(a_last_gives_item, advance && in_s.last_byte,
    out_valid_q && out_q.request_end, "last byte gave no closing item")

endmodule

`default_nettype wire
